### rtl/core/sha1_pkg.sv
package sha1_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [5:0] PAD_LEN_POS = 6'd56;
	localparam int unsigned ROUNDS = 80;

	// byte source selection for the datapath
	localparam logic [1:0] SRC_DATA = 2'd0;
	localparam logic [1:0] SRC_PAD80 = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic put;          // write one byte at the current position
		logic [1:0] src;    // which byte goes in
		logic [2:0] len_idx;// length byte index, 0 is most significant
		logic count;        // add 8 to the bit length
		logic snap_len;     // capture bit length for padding
		logic start;        // load round vars from chain
		logic round;        // run one round
		logic fold;         // add round vars into chain
		logic reinit;       // back to initial values
		logic [2:0] out_sel;
	} sha1_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [5:0] pos;
		logic last_round;
	} sha1_stat_t;

endpackage

### rtl/core/sha1_datapath.sv
module sha1_datapath (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input sha1_pkg::sha1_cmd_t cmd,
	output sha1_pkg::sha1_stat_t stat,
	output logic [31:0] digest_word
);
	import sha1_pkg::*;

	logic [31:0] chain_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] bitlen_q, len_snap_q;
	logic [5:0] pos_q;
	logic [6:0] rnd_q;
	logic [7:0] byte_in;
	logic [31:0] w, f, k, t;
	logic [3:0] ri;

	// byte mux
	always_comb begin
		case (cmd.src)
			SRC_DATA: byte_in = data_byte;
			SRC_PAD80: byte_in = 8'h80;
			SRC_ZERO: byte_in = 8'h00;
			SRC_LEN: byte_in = len_snap_q[(7 - cmd.len_idx) * 8 +: 8];
			default: byte_in = 8'h00;
		endcase
	end

	// round function
	assign ri = rnd_q[3:0];
	always_comb begin
		logic [31:0] x;
		x = w_q[ri + 4'd13] ^ w_q[ri + 4'd8] ^ w_q[ri + 4'd2] ^ w_q[ri];
		w = (rnd_q < 7'd16) ? w_q[ri] : {x[30:0], x[31]};
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
	end

	// block words and round schedule
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			if (pos_q[1:0] == 2'd0) begin
				w_q[pos_q[5:2]] <= {byte_in, 24'd0};
			end else begin
				w_q[pos_q[5:2]] <= w_q[pos_q[5:2]] |
					({24'd0, byte_in} << ((5'd3 - {3'd0, pos_q[1:0]}) * 5'd8));
			end
		end else if (cmd.round) begin
			w_q[ri] <= w;
		end
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.snap_len) begin
			len_snap_q <= bitlen_q;
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '{H0, H1, H2, H3, H4};
			bitlen_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.put) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count) begin
				bitlen_q <= bitlen_q + 64'd8;
			end
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (cmd.fold) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.reinit) begin
				chain_q <= '{H0, H1, H2, H3, H4};
				bitlen_q <= '0;
				pos_q <= '0;
			end
		end
	end

	assign stat.pos = pos_q;
	assign stat.last_round = (rnd_q == 7'(ROUNDS - 1));
	assign digest_word = chain_q[cmd.out_sel];

endmodule

### rtl/core/sha1_ctrl.sv
module sha1_ctrl (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic byte_present,
	input logic end_of_message,
	input logic out_stall,
	output logic out_valid,
	output logic [2:0] word_position,
	output logic final_word,
	input sha1_pkg::sha1_stat_t stat,
	output sha1_pkg::sha1_cmd_t cmd
);
	import sha1_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_PAD = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q, state_d;
	logic fin_q, fin_d;       // 0x80 pad byte still to write
	logic pad_q, pad_d;       // message ended, finishing blocks
	logic lenph_q, lenph_d;   // writing length bytes
	logic [2:0] li_q, li_d;
	logic [2:0] oi_q, oi_d;
	logic take;

	assign stall = (state_q != ST_IDLE);
	assign take = valid && !stall;
	assign out_valid = (state_q == ST_OUT);
	assign word_position = oi_q;
	assign final_word = (oi_q == 3'd4);

	always_comb begin
		cmd = '0;
		cmd.len_idx = li_q;
		cmd.out_sel = oi_q;
		state_d = state_q;
		fin_d = fin_q;
		pad_d = pad_q;
		lenph_d = lenph_q;
		li_d = li_q;
		oi_d = oi_q;
		case (state_q)
			ST_IDLE: begin
				if (take && byte_present) begin
					// data byte; end handled after
					cmd.put = 1'b1;
					cmd.src = SRC_DATA;
					cmd.count = 1'b1;
					fin_d = end_of_message;
					pad_d = end_of_message;
					lenph_d = 1'b0;
					li_d = '0;
					if (stat.pos == 6'd63) begin
						cmd.start = 1'b1;
						state_d = ST_ROUND;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end else if (take && end_of_message) begin
					fin_d = 1'b1;
					pad_d = 1'b1;
					lenph_d = 1'b0;
					li_d = '0;
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.put = 1'b1;
				if (!lenph_q && !fin_q) begin
					cmd.src = SRC_ZERO;
				end else if (lenph_q) begin
					cmd.src = SRC_LEN;
				end else begin
					// first pad cycle: 0x80 and capture length
					cmd.src = SRC_PAD80;
					cmd.snap_len = 1'b1;
				end
				// fin_q marks the pending 0x80
				fin_d = 1'b0;
				if (lenph_q) begin
					li_d = li_q + 3'd1;
				end else if (stat.pos + 6'd1 == PAD_LEN_POS) begin
					lenph_d = 1'b1;
				end
				if (stat.pos == 6'd63) begin
					cmd.start = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (stat.last_round) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (lenph_q && li_q == 3'd0 && !fin_q) begin
					// length written: block was the final one
					state_d = ST_OUT;
					oi_d = '0;
				end else if (pad_q) begin
					// padding spills into another block
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					oi_d = oi_q + 3'd1;
					if (oi_q == 3'd4) begin
						cmd.reinit = 1'b1;
						lenph_d = 1'b0;
						pad_d = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			pad_q <= 1'b0;
			lenph_q <= 1'b0;
			li_q <= '0;
			oi_q <= '0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			pad_q <= pad_d;
			lenph_q <= lenph_d;
			li_q <= li_d;
			oi_q <= oi_d;
		end
	end

endmodule

### rtl/core/sha1_message_digest_unit.sv
// a byte that fills no block is taken while idle; a byte that fills a block starts 80 rounds
// and a fold, one round per cycle in a single round unit
// end of message: pad bytes one per cycle, one or two compressions, then five words
// no new byte is taken until a block's rounds and fold are done; stall is high outside idle
// reset: chain words to the initial values, bit count and control to zero
module sha1_message_digest_unit (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [7:0] data_byte,
	input logic byte_present,
	input logic end_of_message,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] digest_word,
	output logic [2:0] word_position,
	output logic final_word
);
	import sha1_pkg::*;

	sha1_cmd_t cmd;
	sha1_stat_t stat;

	sha1_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.byte_present(byte_present), .end_of_message(end_of_message),
		.out_stall(out_stall), .out_valid(out_valid),
		.word_position(word_position), .final_word(final_word),
		.stat(stat), .cmd(cmd)
	);

	sha1_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte),
		.cmd(cmd), .stat(stat), .digest_word(digest_word)
	);

	// no byte is taken in while a word goes out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stall) else $error("output during input");
	// final word returns to idle
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && final_word |=> !stall) else $error("no return");
	// final flag only on word four
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_word |-> word_position == 3'd4) else $error("bad final");

endmodule
